### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg
// Types shared by the trial division primality test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

	localparam int unsigned FIELD_WIDTH = 32;
	localparam int unsigned OUT_DATA_WIDTH = 8;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIVIDE = 4'b0010,
		ST_CHECK  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

### rtl/core/tdp_div.sv
// ----------------------------------------------------------------------------
// tdp_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdp_div #(
	parameter int unsigned NW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NW-1:0]       dividend,
	input  logic [NW-1:0]       divisor,
	output tdp_pkg::div_status_t status,
	output logic [NW-1:0]       quotient,
	output logic [NW-1:0]       remainder
);

	localparam int unsigned CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] dvd_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] quo_q;

	logic [NW:0]   trial;
	logic [NW:0]   diff;
	logic          qbit;

	assign trial = {rem_q, dvd_q[NW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = !diff[NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], qbit};
			rem_q <= qbit ? diff[NW-1:0] : trial[NW-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

	`ASSERT_IMP(a_rem_below_divisor, clk, arst_n, done_q && divisor != '0, rem_q < divisor)
	`ASSERT_IMP(a_busy_done_excl, clk, arst_n, done_q, !busy_q)

endmodule

### rtl/core/trial_division_primality_test_top.sv
// ----------------------------------------------------------------------------
// trial_division_primality_test_top
// Streaming primality test by trial division with a bit-serial divider.
// ----------------------------------------------------------------------------
// Each transfer on the slave side carries one unsigned number; one transfer
// on the master side answers it with prime_flag. Values 0 and 1 are not
// prime, 2 and 3 are prime, other even values are not prime; these go to
// the result without division. Odd values from 5 up are divided by 3, 5,
// 7, ... while the divisor does not exceed the quotient and none divides
// the value exactly. NW = min(VALUE_WIDTH, 32) is the width of the
// bit-serial divider that resolves one quotient bit per cycle; a prime near
// 2^32 needs about 32768 divisors. One number is worked on at a time; the
// next is taken while the previous result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trial_division_primality_test_top #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] prime_flag, [7:1] zero
);

	localparam int unsigned NW = (VALUE_WIDTH < tdp_pkg::FIELD_WIDTH) ?
		VALUE_WIDTH : tdp_pkg::FIELD_WIDTH;

	tdp_pkg::state_t      state_q;
	tdp_pkg::div_status_t div_st;
	logic                 start_q;
	logic                 m_tvalid_q;
	logic                 res_q;
	logic                 flag_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        div_q;
	logic [NW-1:0]        quo;
	logic [NW-1:0]        rem;
	logic [NW-1:0]        n_in;
	logic                 in_xfer;
	logic                 out_free;
	logic                 trivial_in;
	logic                 check_end;

	assign n_in       = s_tdata[NW-1:0];
	assign s_tready   = (state_q == tdp_pkg::ST_IDLE);
	assign in_xfer    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign trivial_in = (n_in <= NW'(3)) || !n_in[0];
	assign check_end  = (div_q > quo) || (rem == '0);

	tdp_div #(
		.NW(NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (n_q),
		.divisor  (div_q),
		.status   (div_st),
		.quotient (quo),
		.remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tdp_pkg::ST_IDLE;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= (in_xfer && !trivial_in) ||
				(state_q == tdp_pkg::ST_CHECK && !check_end);
			if (state_q == tdp_pkg::ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				tdp_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (trivial_in) begin
							state_q <= tdp_pkg::ST_FINISH;
						end else begin
							state_q <= tdp_pkg::ST_DIVIDE;
						end
					end
				end
				tdp_pkg::ST_DIVIDE: begin
					if (div_st.done) begin
						state_q <= tdp_pkg::ST_CHECK;
					end
				end
				tdp_pkg::ST_CHECK: begin
					if (check_end) begin
						state_q <= tdp_pkg::ST_FINISH;
					end else begin
						state_q <= tdp_pkg::ST_DIVIDE;
					end
				end
				tdp_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= tdp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tdp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q   <= n_in;
			div_q <= NW'(3);
			res_q <= (n_in == NW'(2)) || (n_in == NW'(3));
		end
		if (state_q == tdp_pkg::ST_CHECK) begin
			if (div_q > quo) begin
				res_q <= 1'b1;
			end else if (rem == '0) begin
				res_q <= 1'b0;
			end else begin
				div_q <= div_q + NW'(2);
			end
		end
		if (state_q == tdp_pkg::ST_FINISH && out_free) begin
			flag_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, flag_q};

	`ASSERT_IMP(a_done_in_divide, clk, arst_n, div_st.done, state_q == tdp_pkg::ST_DIVIDE)
	`ASSERT_IMP(a_check_div_odd, clk, arst_n, state_q == tdp_pkg::ST_CHECK, div_q[0] && div_q >= NW'(3))
	`ASSERT_NXT(a_start_busy, clk, arst_n, start_q, div_st.busy)

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trial_division_primality_test_top. Numbers go in
// on the slave stream and verdicts come back on the master stream. A short
// table covers the small cases, the field extremes and the square-of-divisor
// bound. A random mix of small values, large values with a small factor,
// medium values and semiprimes follows. Each verdict is checked in order
// against the table or a trial-division model. Both streams idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned VALUE_WIDTH = 32;
	localparam int unsigned STALL_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 81;
	localparam int unsigned ODD_FACTORS [5] = '{3, 5, 7, 11, 13};

	typedef struct packed {
		logic [tdp_pkg::FIELD_WIDTH-1:0] number;
		bit                              typed;
		bit                              verdict;
	} probe_t;

	typedef struct {
		logic [tdp_pkg::FIELD_WIDTH-1:0] number;
		bit                              verdict;
	} verdict_t;

	localparam int unsigned PROBE_COUNT = 19;
	localparam probe_t PROBES [PROBE_COUNT] = '{
		'{32'd0,          1'b1, 1'b0},
		'{32'd1,          1'b1, 1'b0},
		'{32'd2,          1'b1, 1'b1},
		'{32'd3,          1'b1, 1'b1},
		'{32'd4,          1'b1, 1'b0},
		'{32'd5,          1'b0, 1'b0},
		'{32'd7,          1'b0, 1'b0},
		'{32'd9,          1'b0, 1'b0},
		'{32'd25,         1'b0, 1'b0},
		'{32'd121,        1'b0, 1'b0},
		'{32'd4087,       1'b0, 1'b0},
		'{32'd10007,      1'b0, 1'b0},
		'{32'd65521,      1'b0, 1'b0},
		'{32'd65535,      1'b0, 1'b0},
		'{32'h5555_5555,  1'b0, 1'b0},
		'{32'hAAAA_AAAA,  1'b1, 1'b0},
		'{32'h8000_0000,  1'b1, 1'b0},
		'{32'hFFFF_FFFE,  1'b1, 1'b0},
		'{32'hFFFF_FFFF,  1'b0, 1'b0}
	};

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [tdp_pkg::FIELD_WIDTH-1:0]    s_tdata;    // [31:0] number
	logic                               m_tvalid;
	logic                               m_tready;
	logic [tdp_pkg::OUT_DATA_WIDTH-1:0] m_tdata;    // [0] prime_flag, [7:1] zero

	verdict_t    pending_verdicts [$];
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	bit          steady_flow;

	trial_division_primality_test_top #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_prime_by_division(input logic [tdp_pkg::FIELD_WIDTH-1:0] raw);
		bit [63:0] n;
		bit [63:0] divisor;
		n = 64'(raw);
		if (VALUE_WIDTH < 32)
			n = n & ((64'd1 << VALUE_WIDTH) - 64'd1);
		if (n <= 64'd1)
			return 1'b0;
		if (n <= 64'd3)
			return 1'b1;
		if (n[0] == 1'b0)
			return 1'b0;
		for (divisor = 64'd3; divisor * divisor <= n; divisor += 64'd2)
			if (n % divisor == 64'd0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady_flow)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	task automatic send_number(input logic [tdp_pkg::FIELD_WIDTH-1:0] n, input bit typed,
			input bit verdict);
		int unsigned gap;
		verdict_t    entry;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= n;
		do @(posedge clk); while (!s_tready);
		entry.number  = n;
		entry.verdict = typed ? verdict : is_prime_by_division(n);
		pending_verdicts.push_back(entry);
	endtask

	initial begin : stimulus
		logic [tdp_pkg::FIELD_WIDTH-1:0] n;
		logic [tdp_pkg::FIELD_WIDTH-1:0] r;
		int unsigned                     p;
		int unsigned                     q;
		int unsigned                     factor;
		int unsigned                     kind;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		steady_flow  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_COUNT; i++)
			send_number(PROBES[i].number, PROBES[i].typed, PROBES[i].verdict);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady_flow = (i >= 40 && i < 55);
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				n = $urandom_range(0, 4095);
			end else if (kind < 70) begin
				r = $urandom;
				if ($urandom_range(0, 3) == 0) begin
					n = r & ~32'd1;
				end else begin
					factor = ODD_FACTORS[$urandom_range(0, 4)];
					n = r - (r % factor);
				end
			end else if (kind < 85) begin
				n = $urandom_range(0, 32'h0010_0000);
			end else begin
				p = $urandom_range(256, 1023) | 1;
				while (!is_prime_by_division(p))
					p += 2;
				if ($urandom_range(0, 3) == 0) begin
					q = p;
				end else begin
					q = $urandom_range(p, 2047) | 1;
					while (!is_prime_by_division(q))
						q += 2;
				end
				n = p * q;
			end
			send_number(n, 1'b0, 1'b0);
		end
		steady_flow = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("[trial_division_primality_test_top] OK");
		else
			$display("[trial_division_primality_test_top] ERROR");
		$finish;
	end

	initial begin : result_sink
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 7)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : verdict_check
		verdict_t                           head;
		logic [tdp_pkg::OUT_DATA_WIDTH-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected transfer: m_tdata=%h", m_tdata);
				mismatch_count++;
			end else begin
				head = pending_verdicts.pop_front();
				want = tdp_pkg::OUT_DATA_WIDTH'(head.verdict);
				if (m_tdata !== want) begin
					if (mismatch_count < 10)
						$display("number %0d: expected m_tdata=%h, got %h",
							head.number, want, m_tdata);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[trial_division_primality_test_top] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
